[rtl/cpu6502_execute_unit_defines.svh]
// assertion macros for the 6502 execute unit
`ifndef CPU6502_EXECUTE_UNIT_DEFINES_SVH
`define CPU6502_EXECUTE_UNIT_DEFINES_SVH
`ifndef SYNTH
`define CEU_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define CEU_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define CEU_ASSERT_IMP(label, clk, rst_n, pre, post)
`define CEU_ASSERT_NXT(label, clk, rst_n, pre, post)
`endif
`endif

[rtl/ceu_pkg.sv]
// types and constants shared by the 6502 execute unit
`timescale 1ns / 1ps
package ceu_pkg;
    typedef enum logic [5:0] {
        K_ADC = 6'd0,  K_AND = 6'd1,  K_ASL = 6'd2,  K_BCC = 6'd3,  K_BCS = 6'd4,
        K_BEQ = 6'd5,  K_BIT = 6'd6,  K_BMI = 6'd7,  K_BNE = 6'd8,  K_BPL = 6'd9,
        K_BVC = 6'd10, K_BVS = 6'd11, K_CLC = 6'd12, K_CLD = 6'd13, K_CLI = 6'd14,
        K_CLV = 6'd15, K_CMP = 6'd16, K_CPX = 6'd17, K_CPY = 6'd18, K_DEC = 6'd19,
        K_DEX = 6'd20, K_DEY = 6'd21, K_EOR = 6'd22, K_INC = 6'd23, K_INX = 6'd24,
        K_INY = 6'd25, K_JMP = 6'd26, K_JSR = 6'd27, K_LDA = 6'd28, K_LDX = 6'd29,
        K_LDY = 6'd30, K_LSR = 6'd31, K_NOP = 6'd32, K_ORA = 6'd33, K_PHA = 6'd34,
        K_PHP = 6'd35, K_PLA = 6'd36, K_PLP = 6'd37, K_ROL = 6'd38, K_ROR = 6'd39,
        K_RTI = 6'd40, K_RTS = 6'd41, K_SBC = 6'd42, K_SEC = 6'd43, K_SED = 6'd44,
        K_SEI = 6'd45, K_STA = 6'd46, K_STX = 6'd47, K_STY = 6'd48, K_TAX = 6'd49,
        K_TAY = 6'd50, K_TSX = 6'd51, K_TXA = 6'd52, K_TXS = 6'd53, K_TYA = 6'd54
    } t_kind;

    localparam logic [7:0] FLAG_MASK = 8'hCF;
    localparam logic [7:0] STATUS_ONE = 8'h20;
    localparam logic [7:0] PUSH_BITS = 8'h30;
    localparam logic [7:0] STACK_PAGE = 8'h01;
    localparam logic [15:0] JSR_RET_OFS = 16'd3;

    typedef struct packed {
        logic [5:0]  kind;
        logic [7:0]  operand;
        logic [15:0] target_address;
        logic        on_accumulator;
        logic [15:0] current_pc;
        logic [23:0] stack_bytes;
    } t_in;

    typedef struct packed {
        logic        write_enable;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic        last;
        logic        redirect;
        logic [15:0] next_pc;
        logic [7:0]  acc_out;
        logic [7:0]  status_out;
    } t_out;

    // classified request as it sits in the queue
    typedef struct packed {
        logic [5:0]  kind;
        logic        is_jsr;
        logic        is_branch;
        logic [7:0]  operand;
        logic [15:0] target_address;
        logic        on_accumulator;
        logic [15:0] ret_pc;
        logic [23:0] stack_bytes;
    } t_op;
endpackage

[rtl/ceu_front.sv]
// front end: accepts requests, classifies them and precomputes the return address
`timescale 1ns / 1ps
module ceu_front (
    input  ceu_pkg::t_in  i_req,
    output ceu_pkg::t_op  o_op
);
    always_comb begin
        o_op.kind           = i_req.kind;
        o_op.is_jsr         = (i_req.kind == ceu_pkg::K_JSR);
        o_op.is_branch      = (i_req.kind == ceu_pkg::K_BCC) || (i_req.kind == ceu_pkg::K_BCS)
                           || (i_req.kind == ceu_pkg::K_BEQ) || (i_req.kind == ceu_pkg::K_BMI)
                           || (i_req.kind == ceu_pkg::K_BNE) || (i_req.kind == ceu_pkg::K_BPL)
                           || (i_req.kind == ceu_pkg::K_BVC) || (i_req.kind == ceu_pkg::K_BVS);
        o_op.operand        = i_req.operand;
        o_op.target_address = i_req.target_address;
        o_op.on_accumulator = i_req.on_accumulator;
        o_op.ret_pc         = i_req.current_pc + ceu_pkg::JSR_RET_OFS;
        o_op.stack_bytes    = i_req.stack_bytes;
    end
endmodule

[rtl/ceu_queue.sv]
// two-entry request queue between front and back
`timescale 1ns / 1ps
`include "cpu6502_execute_unit_defines.svh"
module ceu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ceu_pkg::t_op  i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ceu_pkg::t_op  o_data
);
    ceu_pkg::t_op r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    `CEU_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, o_full, !i_push || i_pop)
    `CEU_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, !o_valid, !i_pop)
    `CEU_ASSERT_NXT(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3)
endmodule

[rtl/ceu_back.sv]
// back end: register file, flags, alu and result register
`timescale 1ns / 1ps
`include "cpu6502_execute_unit_defines.svh"
module ceu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  ceu_pkg::t_op  i_op,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output ceu_pkg::t_out o_res
);
    logic [7:0] r_a, r_x, r_y, r_sp, r_p;
    logic [7:0] n_a, n_x, n_y, n_sp, n_p;
    logic       r_vld, r_half;   // r_half: first jsr byte already emitted
    logic       n_half;
    ceu_pkg::t_out r_res, n_res;

    logic       slot_free, fire;
    logic [7:0] m, b0, b1, b2, v, r, cin8, addm;
    logic [8:0] sum;
    logic       we, redir, cond, last;
    logic [15:0] wa, npc;
    logic [7:0]  wd;

    assign slot_free = !r_vld || i_ready;
    assign fire      = i_valid && slot_free;
    assign o_pop     = fire && (!i_op.is_jsr || r_half);
    assign o_valid   = r_vld;
    assign o_res     = r_res;

    always_comb begin
        m = i_op.operand;
        b0 = i_op.stack_bytes[7:0];
        b1 = i_op.stack_bytes[15:8];
        b2 = i_op.stack_bytes[23:16];
        n_a = r_a; n_x = r_x; n_y = r_y; n_sp = r_sp; n_p = r_p;
        we = 1'b0; wa = 16'd0; wd = 8'd0; redir = 1'b0; npc = 16'd0;
        cond = 1'b0; last = 1'b1; n_half = r_half;
        v = i_op.on_accumulator ? r_a : m;
        cin8 = {7'd0, r_p[0]};
        addm = (i_op.kind == ceu_pkg::K_SBC) ? ~m : m;
        sum = {1'b0, r_a} + {1'b0, addm} + {8'd0, r_p[0]};
        r = 8'd0;
        unique case (i_op.kind)
            ceu_pkg::K_ADC, ceu_pkg::K_SBC: begin
                n_a = sum[7:0]; n_p[0] = sum[8];
                n_p[6] = (~(r_a[7] ^ addm[7])) & (r_a[7] ^ sum[7]);
                n_p[1] = (sum[7:0] == 8'd0); n_p[7] = sum[7];
            end
            ceu_pkg::K_AND, ceu_pkg::K_EOR, ceu_pkg::K_ORA, ceu_pkg::K_LDA: begin
                if (i_op.kind == ceu_pkg::K_AND) n_a = r_a & m;
                else if (i_op.kind == ceu_pkg::K_EOR) n_a = r_a ^ m;
                else if (i_op.kind == ceu_pkg::K_ORA) n_a = r_a | m;
                else n_a = m;
                n_p[1] = (n_a == 8'd0); n_p[7] = n_a[7];
            end
            ceu_pkg::K_ASL, ceu_pkg::K_LSR, ceu_pkg::K_ROL, ceu_pkg::K_ROR: begin
                if (i_op.kind == ceu_pkg::K_ASL) begin
                    n_p[0] = v[7]; r = {v[6:0], 1'b0};
                end else if (i_op.kind == ceu_pkg::K_LSR) begin
                    n_p[0] = v[0]; r = {1'b0, v[7:1]};
                end else if (i_op.kind == ceu_pkg::K_ROL) begin
                    n_p[0] = v[7]; r = {v[6:0], cin8[0]};
                end else begin
                    n_p[0] = v[0]; r = {cin8[0], v[7:1]};
                end
                n_p[1] = (r == 8'd0); n_p[7] = r[7];
                if (i_op.on_accumulator) n_a = r;
                else begin we = 1'b1; wa = i_op.target_address; wd = r; end
            end
            ceu_pkg::K_BCC: cond = !r_p[0];
            ceu_pkg::K_BCS: cond = r_p[0];
            ceu_pkg::K_BEQ: cond = r_p[1];
            ceu_pkg::K_BNE: cond = !r_p[1];
            ceu_pkg::K_BMI: cond = r_p[7];
            ceu_pkg::K_BPL: cond = !r_p[7];
            ceu_pkg::K_BVC: cond = !r_p[6];
            ceu_pkg::K_BVS: cond = r_p[6];
            ceu_pkg::K_BIT: begin
                n_p[1] = ((r_a & m) == 8'd0); n_p[7] = m[7]; n_p[6] = m[6];
            end
            ceu_pkg::K_CLC: n_p[0] = 1'b0;
            ceu_pkg::K_CLD: n_p[3] = 1'b0;
            ceu_pkg::K_CLI: n_p[2] = 1'b0;
            ceu_pkg::K_CLV: n_p[6] = 1'b0;
            ceu_pkg::K_SEC: n_p[0] = 1'b1;
            ceu_pkg::K_SED: n_p[3] = 1'b1;
            ceu_pkg::K_SEI: n_p[2] = 1'b1;
            ceu_pkg::K_CMP, ceu_pkg::K_CPX, ceu_pkg::K_CPY: begin
                if (i_op.kind == ceu_pkg::K_CMP) r = r_a;
                else if (i_op.kind == ceu_pkg::K_CPX) r = r_x;
                else r = r_y;
                sum = {1'b0, r} + {1'b0, ~m} + 9'd1;
                n_p[0] = sum[8]; n_p[1] = (sum[7:0] == 8'd0); n_p[7] = sum[7];
            end
            ceu_pkg::K_DEC, ceu_pkg::K_INC: begin
                wd = (i_op.kind == ceu_pkg::K_DEC) ? m - 8'd1 : m + 8'd1;
                n_p[1] = (wd == 8'd0); n_p[7] = wd[7];
                we = 1'b1; wa = i_op.target_address;
            end
            ceu_pkg::K_DEX, ceu_pkg::K_INX, ceu_pkg::K_LDX, ceu_pkg::K_TAX,
            ceu_pkg::K_TSX: begin
                if (i_op.kind == ceu_pkg::K_DEX) n_x = r_x - 8'd1;
                else if (i_op.kind == ceu_pkg::K_INX) n_x = r_x + 8'd1;
                else if (i_op.kind == ceu_pkg::K_LDX) n_x = m;
                else if (i_op.kind == ceu_pkg::K_TAX) n_x = r_a;
                else n_x = r_sp;
                n_p[1] = (n_x == 8'd0); n_p[7] = n_x[7];
            end
            ceu_pkg::K_DEY, ceu_pkg::K_INY, ceu_pkg::K_LDY, ceu_pkg::K_TAY: begin
                if (i_op.kind == ceu_pkg::K_DEY) n_y = r_y - 8'd1;
                else if (i_op.kind == ceu_pkg::K_INY) n_y = r_y + 8'd1;
                else if (i_op.kind == ceu_pkg::K_LDY) n_y = m;
                else n_y = r_a;
                n_p[1] = (n_y == 8'd0); n_p[7] = n_y[7];
            end
            ceu_pkg::K_TXA, ceu_pkg::K_TYA: begin
                n_a = (i_op.kind == ceu_pkg::K_TXA) ? r_x : r_y;
                n_p[1] = (n_a == 8'd0); n_p[7] = n_a[7];
            end
            ceu_pkg::K_TXS: n_sp = r_x;
            ceu_pkg::K_JMP: begin redir = 1'b1; npc = i_op.target_address; end
            ceu_pkg::K_JSR: begin
                // two passes over the same queue entry: high byte, then low byte
                we = 1'b1; wa = {ceu_pkg::STACK_PAGE, r_sp}; n_sp = r_sp - 8'd1;
                if (!r_half) begin
                    wd = i_op.ret_pc[15:8]; last = 1'b0; n_half = 1'b1;
                end else begin
                    wd = i_op.ret_pc[7:0]; redir = 1'b1; npc = i_op.target_address;
                    n_half = 1'b0;
                end
            end
            ceu_pkg::K_PHA, ceu_pkg::K_PHP: begin
                we = 1'b1; wa = {ceu_pkg::STACK_PAGE, r_sp}; n_sp = r_sp - 8'd1;
                wd = (i_op.kind == ceu_pkg::K_PHA) ? r_a
                                                   : ((r_p & ceu_pkg::FLAG_MASK) | ceu_pkg::PUSH_BITS);
            end
            ceu_pkg::K_PLA: begin
                n_sp = r_sp + 8'd1; n_a = b0; n_p[1] = (b0 == 8'd0); n_p[7] = b0[7];
            end
            ceu_pkg::K_PLP: begin n_sp = r_sp + 8'd1; n_p = b0 & ceu_pkg::FLAG_MASK; end
            ceu_pkg::K_RTI: begin
                n_sp = r_sp + 8'd3; n_p = b0 & ceu_pkg::FLAG_MASK;
                redir = 1'b1; npc = {b2, b1};
            end
            ceu_pkg::K_RTS: begin n_sp = r_sp + 8'd2; redir = 1'b1; npc = {b1, b0}; end
            ceu_pkg::K_STA: begin we = 1'b1; wa = i_op.target_address; wd = r_a; end
            ceu_pkg::K_STX: begin we = 1'b1; wa = i_op.target_address; wd = r_x; end
            ceu_pkg::K_STY: begin we = 1'b1; wa = i_op.target_address; wd = r_y; end
            default: ;
        endcase
        if (i_op.is_branch && cond) begin redir = 1'b1; npc = i_op.target_address; end
        n_res.write_enable  = we;
        n_res.write_address = wa;
        n_res.write_data    = wd;
        n_res.last          = last;
        n_res.redirect      = redir;
        n_res.next_pc       = npc;
        n_res.acc_out       = n_a;
        n_res.status_out    = (n_p & ceu_pkg::FLAG_MASK) | ceu_pkg::STATUS_ONE;
    end

    always_ff @(posedge i_clk) begin
        if (fire) r_res <= n_res;
        if (!i_rst_n) begin
            r_a <= 8'd0; r_x <= 8'd0; r_y <= 8'd0; r_sp <= 8'd0; r_p <= 8'd0;
            r_vld <= 1'b0; r_half <= 1'b0;
        end else begin
            if (fire) begin
                r_a <= n_a; r_x <= n_x; r_y <= n_y; r_sp <= n_sp;
                r_p <= n_p & ceu_pkg::FLAG_MASK; r_half <= n_half;
            end
            if (slot_free) r_vld <= i_valid;
        end
    end

    `CEU_ASSERT_IMP(a_half_only_jsr, i_clk, i_rst_n, r_half && i_valid, i_op.is_jsr)
    `CEU_ASSERT_IMP(a_status_bit5, i_clk, i_rst_n, r_vld, r_res.status_out[5] && !r_res.status_out[4])
    `CEU_ASSERT_NXT(a_jsr_first_not_last, i_clk, i_rst_n, fire && i_op.is_jsr && !r_half,
                    r_vld && !r_res.last && r_half)
endmodule

[rtl/cpu6502_execute_unit.sv]
// 6502 execute unit top level: front classifier, request queue, execute back end
// an accepted request passes the queue register, then the result register
// throughput: one request per cycle while the output is ready; jsr takes two back-end passes (two stack bytes)
// the front takes a request whenever the 2-entry queue has room, so a stalled output
// does not stop acceptance until the queue fills
// synchronous active-low reset clears a, x, y, sp, flags, the queue and the result valid
`timescale 1ns / 1ps
module cpu6502_execute_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ceu_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output ceu_pkg::t_out o_data
);
    // classified request from the front
    ceu_pkg::t_op f_op;
    // queue head toward the back end
    ceu_pkg::t_op q_op;
    logic         q_full, q_valid, q_pop;

    ceu_front u_front (
        .i_req (i_data),
        .o_op  (f_op)
    );

    // accept whenever the queue has a free slot
    assign o_ready = !q_full;

    ceu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !q_full),
        .i_data  (f_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_op)
    );

    // back end owns the architectural registers and the result register
    ceu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_op    (q_op),
        .o_pop   (q_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_data)
    );
endmodule

[test/cpu6502_execute_unit_test.sv]
// self-checking testbench for the 6502 execute unit: directed and random instruction streams against a predictor
`timescale 1ns / 1ps
import ceu_pkg::*;

// scoreboard: predicts 6502 register effects and holds the expected result words
class cpu6502_scoreboard;
    logic [7:0] acc, reg_x, reg_y, sp, flags;
    t_out pending[$];
    int n_fail;
    int n_seen;

    function void clear_state();
        acc = 8'd0; reg_x = 8'd0; reg_y = 8'd0; sp = 8'd0; flags = 8'd0;
        n_fail = 0; n_seen = 0;
        pending.delete();
    endfunction

    function void set_f(logic [7:0] f, logic on);
        if (on) flags = flags | f;
        else flags = flags & ~f;
    endfunction

    function void set_nz(logic [7:0] v);
        set_f(8'h02, v == 8'd0);
        set_f(8'h80, v[7]);
    endfunction

    function void add_carry(logic [7:0] m);
        logic [8:0] sum;
        sum = {1'b0, acc} + {1'b0, m} + {8'd0, flags[0]};
        set_f(8'h01, sum[8]);
        set_f(8'h40, (~(acc[7] ^ m[7])) & (acc[7] ^ sum[7]));
        acc = sum[7:0];
        set_nz(acc);
    endfunction

    function void compare(logic [7:0] r, logic [7:0] m);
        set_nz(r - m);
        set_f(8'h01, r >= m);
    endfunction

    function t_out make_word(logic we, logic [15:0] wa, logic [7:0] wd, logic lst,
                             logic rd, logic [15:0] npc);
        t_out o;
        o.write_enable = we;
        o.write_address = we ? wa : 16'd0;
        o.write_data = we ? wd : 8'd0;
        o.last = lst;
        o.redirect = rd;
        o.next_pc = rd ? npc : 16'd0;
        o.acc_out = acc;
        o.status_out = (flags & FLAG_MASK) | STATUS_ONE;
        return o;
    endfunction

    // note one accepted request and queue its expected results
    function void note_request(t_in r);
        logic we, rd, br, cond;
        logic [15:0] wa, npc, ret;
        logic [7:0] wd, v, res;
        logic cin;
        we = 1'b0; rd = 1'b0; br = 1'b0; cond = 1'b0; wa = 16'd0; npc = 16'd0; wd = 8'd0;
        case (r.kind)
            K_ADC: add_carry(r.operand);
            K_AND: begin acc = acc & r.operand; set_nz(acc); end
            K_ASL, K_LSR, K_ROL, K_ROR: begin
                v = r.on_accumulator ? acc : r.operand;
                cin = flags[0];
                case (r.kind)
                    K_ASL: begin set_f(8'h01, v[7]); res = {v[6:0], 1'b0}; end
                    K_LSR: begin set_f(8'h01, v[0]); res = {1'b0, v[7:1]}; end
                    K_ROL: begin set_f(8'h01, v[7]); res = {v[6:0], cin}; end
                    default: begin set_f(8'h01, v[0]); res = {cin, v[7:1]}; end
                endcase
                set_nz(res);
                if (r.on_accumulator) acc = res;
                else begin we = 1'b1; wa = r.target_address; wd = res; end
            end
            K_BCC: begin br = 1'b1; cond = !flags[0]; end
            K_BCS: begin br = 1'b1; cond = flags[0]; end
            K_BEQ: begin br = 1'b1; cond = flags[1]; end
            K_BMI: begin br = 1'b1; cond = flags[7]; end
            K_BNE: begin br = 1'b1; cond = !flags[1]; end
            K_BPL: begin br = 1'b1; cond = !flags[7]; end
            K_BVC: begin br = 1'b1; cond = !flags[6]; end
            K_BVS: begin br = 1'b1; cond = flags[6]; end
            K_BIT: begin
                set_f(8'h02, (acc & r.operand) == 8'd0);
                set_f(8'h80, r.operand[7]);
                set_f(8'h40, r.operand[6]);
            end
            K_CLC: set_f(8'h01, 1'b0);
            K_CLD: set_f(8'h08, 1'b0);
            K_CLI: set_f(8'h04, 1'b0);
            K_CLV: set_f(8'h40, 1'b0);
            K_CMP: compare(acc, r.operand);
            K_CPX: compare(reg_x, r.operand);
            K_CPY: compare(reg_y, r.operand);
            K_DEC: begin
                wd = r.operand - 8'd1; set_nz(wd); we = 1'b1; wa = r.target_address;
            end
            K_INC: begin
                wd = r.operand + 8'd1; set_nz(wd); we = 1'b1; wa = r.target_address;
            end
            K_DEX: begin reg_x = reg_x - 8'd1; set_nz(reg_x); end
            K_DEY: begin reg_y = reg_y - 8'd1; set_nz(reg_y); end
            K_INX: begin reg_x = reg_x + 8'd1; set_nz(reg_x); end
            K_INY: begin reg_y = reg_y + 8'd1; set_nz(reg_y); end
            K_EOR: begin acc = acc ^ r.operand; set_nz(acc); end
            K_ORA: begin acc = acc | r.operand; set_nz(acc); end
            K_JMP: begin rd = 1'b1; npc = r.target_address; end
            K_JSR: begin
                // two stack writes: return high byte then low byte
                ret = r.current_pc + JSR_RET_OFS;
                pending.push_back(make_word(1'b1, {STACK_PAGE, sp}, ret[15:8], 1'b0, 1'b0,
                                            16'd0));
                sp = sp - 8'd1;
                pending.push_back(make_word(1'b1, {STACK_PAGE, sp}, ret[7:0], 1'b1, 1'b1,
                                            r.target_address));
                sp = sp - 8'd1;
                return;
            end
            K_LDA: begin acc = r.operand; set_nz(acc); end
            K_LDX: begin reg_x = r.operand; set_nz(reg_x); end
            K_LDY: begin reg_y = r.operand; set_nz(reg_y); end
            K_PHA, K_PHP: begin
                we = 1'b1; wa = {STACK_PAGE, sp};
                wd = (r.kind == K_PHA) ? acc : ((flags & FLAG_MASK) | PUSH_BITS);
                sp = sp - 8'd1;
            end
            K_PLA: begin sp = sp + 8'd1; acc = r.stack_bytes[7:0]; set_nz(acc); end
            K_PLP: begin sp = sp + 8'd1; flags = r.stack_bytes[7:0] & FLAG_MASK; end
            K_RTI: begin
                sp = sp + 8'd3;
                flags = r.stack_bytes[7:0] & FLAG_MASK;
                rd = 1'b1; npc = r.stack_bytes[23:8];
            end
            K_RTS: begin sp = sp + 8'd2; rd = 1'b1; npc = r.stack_bytes[15:0]; end
            K_SBC: add_carry(~r.operand);
            K_SEC: set_f(8'h01, 1'b1);
            K_SED: set_f(8'h08, 1'b1);
            K_SEI: set_f(8'h04, 1'b1);
            K_STA: begin we = 1'b1; wa = r.target_address; wd = acc; end
            K_STX: begin we = 1'b1; wa = r.target_address; wd = reg_x; end
            K_STY: begin we = 1'b1; wa = r.target_address; wd = reg_y; end
            K_TAX: begin reg_x = acc; set_nz(reg_x); end
            K_TAY: begin reg_y = acc; set_nz(reg_y); end
            K_TSX: begin reg_x = sp; set_nz(reg_x); end
            K_TXA: begin acc = reg_x; set_nz(acc); end
            K_TXS: sp = reg_x;
            K_TYA: begin acc = reg_y; set_nz(acc); end
            default: ;
        endcase
        if (br && cond) begin rd = 1'b1; npc = r.target_address; end
        pending.push_back(make_word(we, wa, wd, 1'b1, rd, npc));
    endfunction

    function void check_result(t_out got);
        t_out want;
        n_seen++;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, got);
            n_fail++;
            return;
        end
        want = pending.pop_front();
        if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
            n_fail++;
        end
    endfunction
endclass

module cpu6502_execute_unit_test;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    t_in i_data = '0;
    logic o_valid;
    logic i_ready = 0;
    t_out o_data;

    cpu6502_scoreboard exec_board;
    int cycle_count = 0;
    int sent = 0;
    bit stim_done = 0;
    bit kind_hit[64];

    cpu6502_execute_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    always #6 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // accept requests and results at the rising edge
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && i_valid && o_ready) begin
            exec_board.note_request(i_data);
            kind_hit[i_data.kind] = 1;
        end
        if (i_rst_n && o_valid && i_ready) exec_board.check_result(o_data);
        if (cycle_count > CYCLE_LIMIT) begin
            $display("cpu6502_execute_unit_test failed");
            $finish;
        end
    end

    // receiver stall pattern, with a quiet stretch of full readiness in the middle
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sent > 900 && sent < 1200) i_ready <= 1;
            else begin
                g = gap_len();
                if (g == 0) i_ready <= 1;
                else begin
                    i_ready <= 0;
                    repeat (g - 1) @(negedge i_clk);
                end
            end
        end
    end

    // called at a falling edge; valid stays high between back-to-back requests
    task automatic send_request(t_in r);
        int g;
        g = (sent < 300 || sent > 600) ? gap_len() : 0;
        if (g > 0) begin
            i_valid <= 0;
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1;
        i_data <= r;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    function automatic t_in rand_request(logic [5:0] k);
        t_in r;
        r.kind = k;
        r.operand = 8'($urandom);
        r.target_address = 16'($urandom);
        r.on_accumulator = 1'($urandom);
        r.current_pc = 16'($urandom);
        r.stack_bytes = 24'($urandom);
        return r;
    endfunction

    task automatic send_kind(logic [5:0] k, logic [7:0] op);
        t_in r;
        r = rand_request(k);
        r.operand = op;
        send_request(r);
    endtask

    initial begin
        t_in r;
        int p;
        exec_board = new();
        exec_board.clear_state();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: adc/sbc overflow and carry edges, bit, shifts on both targets, stack
        send_kind(K_LDA, 8'h7F);
        send_kind(K_ADC, 8'h01);
        send_kind(K_SBC, 8'h00);
        send_kind(K_SEC, 8'h00);
        send_kind(K_SBC, 8'hFF);
        send_kind(K_ADC, 8'hFF);
        send_kind(K_BIT, 8'hC0);
        send_kind(K_BVS, 8'h00);
        send_kind(K_BMI, 8'h00);
        r = rand_request(K_ROL); r.on_accumulator = 1; send_request(r);
        r = rand_request(K_ROR); r.on_accumulator = 0; r.operand = 8'h01; send_request(r);
        send_kind(K_CMP, 8'h00);
        send_kind(K_BEQ, 8'h00);
        send_kind(K_PHP, 8'h00);
        r = rand_request(K_JSR); r.current_pc = 16'hFFFE; send_request(r);
        r = rand_request(K_RTS); r.stack_bytes = 24'hFFFFFF; send_request(r);
        r = rand_request(K_RTI); r.stack_bytes = 24'h0000FF; send_request(r);
        send_kind(K_TSX, 8'h00);
        send_kind(K_TXS, 8'h00);
        send_kind(K_SED, 8'h00);
        send_request(rand_request(6'd63));

        // directed: every opcode once
        for (int k = 0; k < 55; k++) send_request(rand_request(6'(k)));

        // random stream; undefined kinds appear rarely
        for (int n = 0; n < 1900; n++) begin
            p = $urandom_range(0, 99);
            if (p < 3) r = rand_request(6'($urandom_range(55, 63)));
            else r = rand_request(6'($urandom_range(0, 54)));
            if ($urandom_range(0, 9) == 0) r.operand = ($urandom & 1) ? 8'hFF : 8'h00;
            send_request(r);
            // hold off until the block drains once
            if (n == 1000) begin
                i_valid <= 0;
                while (exec_board.pending.size() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
        end
        i_valid <= 0;
        stim_done = 1;

        while (exec_board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        begin
            int kinds;
            kinds = 0;
            foreach (kind_hit[k]) if (kind_hit[k]) kinds++;
            $display("covered %0d requests over %0d distinct kinds, %0d results checked",
                     sent, kinds, exec_board.n_seen);
        end
        if (exec_board.n_fail == 0 && exec_board.pending.size() == 0)
            $display("cpu6502_execute_unit_test passed");
        else
            $display("cpu6502_execute_unit_test failed");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/ceu_pkg.sv
rtl/ceu_front.sv
rtl/ceu_queue.sv
rtl/ceu_back.sv
rtl/cpu6502_execute_unit.sv
test/cpu6502_execute_unit_test.sv
